[rtl/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and constants for the incremental PID controller core.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int MEAS_W     = 16;
   localparam int DRIVE_W    = 15;
   localparam int GAIN_W     = 24;
   localparam int ERR_W      = 17;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   typedef logic [MEAS_W-1:0]     meas_type;
   typedef logic [DRIVE_W-1:0]    drive_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 2'd0,
      CSR_GAIN_P   = 2'd1,
      CSR_GAIN_I   = 2'd2,
      CSR_GAIN_D   = 2'd3
   } csr_index_type;

   localparam drive_type DRIVE_MAX = 15'd20480;

   localparam meas_type SETPOINT_RESET = 16'd9728;
   localparam gain_type GAIN_P_RESET   = 24'd40550;
   localparam gain_type GAIN_I_RESET   = 24'd25;
   localparam gain_type GAIN_D_RESET   = 24'd3051520;

endpackage

[rtl/pidc_req_if.sv]
// ----------------------------------------------------------------------------
// pidc_req_if
// Sample channel: valid/ready handshake carrying one temperature sample.
// ----------------------------------------------------------------------------
interface pidc_req_if;
   import pidc_pkg::*;

   logic     valid;
   logic     ready;
   meas_type measured_value;

   modport source (output valid, output measured_value, input ready);
   modport sink   (input valid, input measured_value, output ready);
endinterface

[rtl/pidc_rsp_if.sv]
// ----------------------------------------------------------------------------
// pidc_rsp_if
// Result channel: valid/ready handshake carrying one drive value.
// ----------------------------------------------------------------------------
interface pidc_rsp_if;
   import pidc_pkg::*;

   logic      valid;
   logic      ready;
   drive_type drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink   (input valid, input drive_value, output ready);
endinterface

[rtl/incremental_pid_controller_core.sv]
// Each sample is held in the sample register, then moves to the drive register
// once that register is empty or its result is being taken; result valid is registered.
// Throughput: one sample per cycle unless results stall; the PID update (three parallel
// multiplies, sum, floor shift, clamp) sits between the sample and drive registers.
// Reset (synchronous, active high): setpoint 38.0, gains at defaults,
// error history and drive cleared to zero, both stages empty.
// ----------------------------------------------------------------------------
// incremental_pid_controller_core
// Velocity-form PID: drive += Kp*de + (Ki*T/2)*(e+e1) + (Kd/T)*d2e, clamped.
// ----------------------------------------------------------------------------
module incremental_pid_controller_core (
   input  logic                          clock,
   input  logic                          reset,
   pidc_req_if.sink                      req_chan,
   pidc_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [pidc_pkg::CSR_IDX_W-1:0] csr_index,
   input  pidc_pkg::csr_data_type        csr_write_data
);
   import pidc_pkg::*;

   meas_type  setpoint_ff;
   gain_type  gain_p_ff;
   gain_type  gain_i_ff;
   gain_type  gain_d_ff;

   logic      s1_valid_ff;
   meas_type  meas_ff;
   logic      rsp_valid_ff;
   err_type   error_prev_ff;
   err_type   error_prev2_ff;
   drive_type drive_prev_ff;

   logic      s1_advance;
   logic      req_accept;

   err_type              err_in;
   logic signed [17:0]   diff1;
   logic signed [17:0]   sum1;
   logic signed [18:0]   diff2;
   logic signed [42:0]   p_term;
   logic signed [42:0]   i_term;
   logic signed [43:0]   d_term;
   logic signed [45:0]   term_sum;
   logic signed [37:0]   term_shift;
   logic signed [38:0]   drive_sum;
   drive_type            drive_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         gain_p_ff   <= GAIN_P_RESET;
         gain_i_ff   <= GAIN_I_RESET;
         gain_d_ff   <= GAIN_D_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SETPOINT: setpoint_ff <= csr_write_data[MEAS_W-1:0];
            CSR_GAIN_P:   gain_p_ff   <= csr_write_data[GAIN_W-1:0];
            CSR_GAIN_I:   gain_i_ff   <= csr_write_data[GAIN_W-1:0];
            CSR_GAIN_D:   gain_d_ff   <= csr_write_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.drive_value = drive_prev_ff;

   // PID arithmetic
   always_comb begin
      err_in     = $signed({1'b0, setpoint_ff}) - $signed({1'b0, meas_ff});
      diff1      = {err_in[ERR_W-1], err_in} - {error_prev_ff[ERR_W-1], error_prev_ff};
      sum1       = {err_in[ERR_W-1], err_in} + {error_prev_ff[ERR_W-1], error_prev_ff};
      diff2      = {{2{err_in[ERR_W-1]}}, err_in}
                 - {error_prev_ff[ERR_W-1], error_prev_ff, 1'b0}
                 + {{2{error_prev2_ff[ERR_W-1]}}, error_prev2_ff};
      p_term     = 43'($signed({1'b0, gain_p_ff})) * 43'(diff1);
      i_term     = 43'($signed({1'b0, gain_i_ff})) * 43'(sum1);
      d_term     = 44'($signed({1'b0, gain_d_ff})) * 44'(diff2);
      term_sum   = 46'(p_term) + 46'(i_term) + 46'(d_term);
      term_shift = term_sum[45:8];
      drive_sum  = $signed({24'd0, drive_prev_ff}) + {term_shift[37], term_shift};
      if (drive_sum < 0) begin
         drive_in = '0;
      end else if (drive_sum > $signed({24'd0, DRIVE_MAX})) begin
         drive_in = DRIVE_MAX;
      end else begin
         drive_in = drive_sum[DRIVE_W-1:0];
      end
   end

   // sample stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         meas_ff <= req_chan.measured_value;
      end
   end

   // result stage and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         error_prev_ff  <= '0;
         error_prev2_ff <= '0;
         drive_prev_ff  <= '0;
      end else begin
         if (s1_advance) begin
            rsp_valid_ff   <= 1'b1;
            error_prev_ff  <= err_in;
            error_prev2_ff <= error_prev_ff;
            drive_prev_ff  <= drive_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_prev_ff <= DRIVE_MAX))
      else $error("drive value above limit");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (error_prev2_ff == $past(error_prev_ff)))
      else $error("error history not shifted");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced transaction produced no result");

   a_stalled_sample_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(meas_ff)))
      else $error("stalled sample lost");
`endif

endmodule
